>>> rtl/ipd_pkg.sv
// Shared types and constants for the IMU packet deframer.
`default_nettype none

package ipd_pkg;

    // Packet layout: start, type, four 16-bit words, checksum.
    localparam int PACKET_BYTES = 11;
    // Bytes held in the shift chain before the checksum arrives.
    localparam int CHAIN_LEN    = PACKET_BYTES - 1;
    localparam int POS_W        = 4;
    localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(PACKET_BYTES - 1);

    // Register reset values.
    localparam logic [7:0] START_BYTE_RST = 8'h55;
    localparam logic [7:0] ACCEL_TYPE_RST = 8'h51;
    localparam logic [7:0] GYRO_TYPE_RST  = 8'h52;
    localparam logic [7:0] ANGLE_TYPE_RST = 8'h53;
    localparam logic [7:0] MAG_TYPE_RST   = 8'h54;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_START_BYTE = 3'd0,
        REG_ACCEL_TYPE = 3'd1,
        REG_GYRO_TYPE  = 3'd2,
        REG_ANGLE_TYPE = 3'd3,
        REG_MAG_TYPE   = 3'd4
    } cfg_reg_t;

    // Packet kind codes.
    typedef enum logic [2:0] {
        KIND_ACCEL = 3'd0,
        KIND_GYRO  = 3'd1,
        KIND_ANGLE = 3'd2,
        KIND_MAG   = 3'd3,
        KIND_OTHER = 3'd4
    } kind_t;

    // One decoded packet.
    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/imu_packet_deframer.sv
// Top level of the IMU packet deframer: framing control, shift chain and output.
//
//   Channel   Signals                                  Direction
//   input     in_valid, in_ready, rx_byte              bytes in
//   output    out_valid, out_ready, kind, value_x/y/z  packets out
//   config    cfg_we, cfg_index, cfg_data              register writes in
//
// A new byte can be accepted on every clock except while a checksum beat is stalled.
// The ten packet bytes before the checksum sit in a chain of byte cells that shift
// only on accepted packet bytes; the checksum beat is checked against a running sum.
// A good packet is loaded into the output register on its checksum beat.
// Only a checksum beat stalls, and only while the previous packet is unread.
// Reset loads the register defaults and returns the framer to hunting.
`default_nettype none

module imu_packet_deframer
    import ipd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              kind,
    output logic signed [15:0]      value_x,
    output logic signed [15:0]      value_y,
    output logic signed [15:0]      value_z,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    logic [7:0]       start_byte_reg;
    logic [7:0]       accel_type_reg;
    logic [7:0]       gyro_type_reg;
    logic [7:0]       angle_type_reg;
    logic [7:0]       mag_type_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;

    logic             in_fire;
    logic             shift_en;
    logic             emit;
    logic [7:0]       chain_data [CHAIN_LEN];
    result_t          result;
    result_t          out_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            accel_type_reg <= ACCEL_TYPE_RST;
            gyro_type_reg  <= GYRO_TYPE_RST;
            angle_type_reg <= ANGLE_TYPE_RST;
            mag_type_reg   <= MAG_TYPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_BYTE: start_byte_reg <= cfg_data;
                REG_ACCEL_TYPE: accel_type_reg <= cfg_data;
                REG_GYRO_TYPE:  gyro_type_reg  <= cfg_data;
                REG_ANGLE_TYPE: angle_type_reg <= cfg_data;
                REG_MAG_TYPE:   mag_type_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Only the checksum beat needs room in the output register.
    assign in_ready = !((pos_reg == POS_CHECKSUM) && out_valid && !out_ready);
    assign in_fire  = in_valid && in_ready;

    // Framing control: byte position and running checksum.
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        shift_en = 1'b0;
        emit     = 1'b0;
        if (in_fire)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == start_byte_reg)
                begin
                    shift_en = 1'b1;
                    sum_next = rx_byte;
                    pos_next = POS_W'(1);
                end
            end
            else if (pos_reg < POS_CHECKSUM)
            begin
                shift_en = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                emit     = (chain_data[CHAIN_LEN-1] == start_byte_reg) &&
                           (sum_reg == rx_byte);
                sum_next = 8'd0;
                pos_next = POS_HUNT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Shift chain: cell 0 takes the newest byte, the last cell holds the start byte.
    for (genvar i = 0; i < CHAIN_LEN; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            ipd_byte_cell u_cell (
                .clk  (clk),
                .shift(shift_en),
                .din  (rx_byte),
                .dout (chain_data[i])
            );
        end
        else
        begin : g_body
            ipd_byte_cell u_cell (
                .clk  (clk),
                .shift(shift_en),
                .din  (chain_data[i-1]),
                .dout (chain_data[i])
            );
        end
    end

    // Decode the packet: packet byte k sits in cell CHAIN_LEN-1-k.
    always_comb
    begin
        if (chain_data[CHAIN_LEN-2] == accel_type_reg)
        begin
            result.kind = KIND_ACCEL;
        end
        else if (chain_data[CHAIN_LEN-2] == gyro_type_reg)
        begin
            result.kind = KIND_GYRO;
        end
        else if (chain_data[CHAIN_LEN-2] == angle_type_reg)
        begin
            result.kind = KIND_ANGLE;
        end
        else if (chain_data[CHAIN_LEN-2] == mag_type_reg)
        begin
            result.kind = KIND_MAG;
        end
        else
        begin
            result.kind = KIND_OTHER;
        end
        result.value_x = {chain_data[CHAIN_LEN-4], chain_data[CHAIN_LEN-3]};
        result.value_y = {chain_data[CHAIN_LEN-6], chain_data[CHAIN_LEN-5]};
        result.value_z = {chain_data[CHAIN_LEN-8], chain_data[CHAIN_LEN-7]};
    end

    ipd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit),
        .load_data(result),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .out_data (out_data)
    );

    assign kind    = out_data.kind;
    assign value_x = out_data.value_x;
    assign value_y = out_data.value_y;
    assign value_z = out_data.value_z;

    // The byte position never runs past the checksum slot.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CHECKSUM)
        else $error("byte position beyond checksum slot");

    // A checksum beat always returns the framer to hunting.
    a_checksum_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (pos_reg == POS_CHECKSUM)) |=> (pos_reg == POS_HUNT))
        else $error("framer did not resume hunting after checksum");

    // A non-start byte while hunting is dropped.
    a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (pos_reg == POS_HUNT) && (rx_byte != start_byte_reg))
        |=> (pos_reg == POS_HUNT))
        else $error("non-start byte left hunt state");

    // A new packet only appears right after an accepted checksum beat.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_fire && (pos_reg == POS_CHECKSUM)))
        else $error("packet emitted without a checksum beat");

endmodule

`default_nettype wire

>>> rtl/ipd_byte_cell.sv
// One byte cell of the packet shift chain.
`default_nettype none

module ipd_byte_cell (
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire logic [7:0] din,
    output logic      [7:0] dout
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Take the neighbor's byte on a shift, otherwise hold.
    always_comb
    begin
        data_next = shift ? din : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

>>> rtl/ipd_out_stage.sv
// Output register holding one decoded packet until the consumer takes it.
`default_nettype none

module ipd_out_stage
    import ipd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    // A load only arrives when the register is empty or being drained.
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
        data_next = load ? load_data : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
